@@ hdl/positional_list_engine_unit_defines.svh @@
// Assertion macros used by the checker file of the positional list engine.
// Depends on nothing; include by bare file name.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("positional list engine: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("positional list engine: same-cycle check failed");

`endif

@@ hdl/ple_pkg.sv @@
// Shared types and constants of the positional list engine.
// Used by the cell, the controller, the top level and the checker.
package ple_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MODE_W     = 3;
    localparam int POS_W      = 5;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int OCNT_W     = 5;
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FIRST = 3'd0,
        MODE_INS_LAST  = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_DEL_FIRST = 3'd3,
        MODE_DEL_LAST  = 3'd4,
        MODE_DEL_POS   = 3'd5,
        MODE_DUMP      = 3'd6
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_ROTATE
    } t_cell_kind;

    typedef struct packed {
        t_cell_kind              kind;
        logic [IDX_W-1:0]        idx;
        logic [CNT_W-1:0]        cnt;
        logic [DATA_WIDTH-1:0]   value;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

endpackage

@@ hdl/ple_cell.sv @@
// One slot of the list: holds an entry and shifts it to or from its neighbors.
// Depends on ple_pkg.
module ple_cell (
    input  logic                           i_clk,
    input  ple_pkg::t_cell_cmd             i_cmd,
    input  logic [ple_pkg::IDX_W-1:0]      i_index,
    input  logic [ple_pkg::DATA_WIDTH-1:0] i_prev,
    input  logic [ple_pkg::DATA_WIDTH-1:0] i_next,
    input  logic [ple_pkg::DATA_WIDTH-1:0] i_head,
    output logic [ple_pkg::DATA_WIDTH-1:0] o_data
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CNT_W-1:0]      w_slot;
    logic [CNT_W-1:0]      w_slot1;

    assign w_slot  = CNT_W'(i_index);
    assign w_slot1 = w_slot + CNT_W'(1);

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.kind)
            CMD_INSERT: begin
                // open a gap at idx, push the tail one slot back
                if (i_index == i_cmd.idx) begin
                    n_data = i_cmd.value;
                end else if (i_index > i_cmd.idx && w_slot <= i_cmd.cnt) begin
                    n_data = i_prev;
                end
            end
            CMD_DELETE: begin
                if (i_index >= i_cmd.idx && w_slot1 < i_cmd.cnt) begin
                    n_data = i_next;
                end
            end
            CMD_ROTATE: begin
                // walk the occupied slots toward the head, wrap the head to the tail
                if (w_slot1 < i_cmd.cnt) begin
                    n_data = i_next;
                end else if (w_slot1 == i_cmd.cnt) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hdl/ple_ctrl.sv @@
// Operation decoder, element count and dump sequencer of the list engine.
// Depends on ple_pkg; drives the command bus of the cell row.
module ple_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ple_pkg::MODE_W-1:0]     i_mode,
    input  logic [ple_pkg::POS_W-1:0]      i_position,
    input  logic [ple_pkg::VALUE_W-1:0]    i_value,
    input  logic [ple_pkg::DATA_WIDTH-1:0] i_head,
    output ple_pkg::t_cell_cmd             o_cmd,
    output logic                           o_busy,
    output logic                           o_strobe,
    output logic [ple_pkg::STATUS_W-1:0]   o_status,
    output logic [ple_pkg::VALUE_W-1:0]    o_entry_value,
    output logic                           o_entry_valid,
    output logic [ple_pkg::OCNT_W-1:0]     o_entry_count,
    output logic                           o_last_of_run
);
    import ple_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_dump, n_dump;
    logic                  r_strobe, n_strobe;
    t_status               r_status, n_status;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic                  r_valid, n_valid;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_last, n_last;

    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_cnt;
    logic                  w_full;
    logic                  w_dump_end;

    assign w_pos      = CMP_W'(i_position);
    assign w_cnt      = CMP_W'(r_count);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_dump_end = ((CNT_W'(r_dump) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dump     = r_dump;
        n_strobe   = 1'b0;
        n_status   = ST_OK;
        n_value    = '0;
        n_valid    = 1'b0;
        n_last     = 1'b0;
        o_cmd.kind  = CMD_HOLD;
        o_cmd.idx   = '0;
        o_cmd.cnt   = r_count;
        o_cmd.value = DATA_WIDTH'($unsigned(i_value));

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    case (i_mode)
                        MODE_INS_FIRST, MODE_INS_LAST: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_cmd.kind = CMD_INSERT;
                                o_cmd.idx  = (i_mode == MODE_INS_FIRST) ? '0
                                                                       : IDX_W'(r_count);
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        MODE_INS_POS: begin
                            if (w_pos == '0 || w_pos > w_cnt + CMP_W'(1)) begin
                                n_status = ST_BAD_POS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_cmd.kind = CMD_INSERT;
                                o_cmd.idx  = IDX_W'(w_pos - CMP_W'(1));
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        MODE_DEL_FIRST, MODE_DEL_LAST: begin
                            // empty list: drop silently
                            if (r_count != '0) begin
                                o_cmd.kind = CMD_DELETE;
                                o_cmd.idx  = (i_mode == MODE_DEL_FIRST) ? '0
                                            : IDX_W'(r_count - CNT_W'(1));
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        MODE_DEL_POS: begin
                            if (w_pos == '0 || w_pos > w_cnt) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                o_cmd.kind = CMD_DELETE;
                                o_cmd.idx  = IDX_W'(w_pos - CMP_W'(1));
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        MODE_DUMP: begin
                            // empty list dumps as one result without an entry
                            if (r_count != '0) begin
                                n_strobe = 1'b0;
                                n_last   = 1'b0;
                                n_dump   = '0;
                                n_state  = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                o_cmd.kind = CMD_ROTATE;
                n_strobe   = 1'b1;
                n_value    = VALUE_W'(i_head);
                n_valid    = 1'b1;
                n_last     = w_dump_end;
                n_dump     = r_dump + IDX_W'(1);
                if (w_dump_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dump      <= n_dump;
        r_status    <= n_status;
        r_value     <= n_value;
        r_valid     <= n_valid;
        r_out_count <= n_count;
        r_last      <= n_last;
    end

    assign o_busy        = (r_state == S_DUMP);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_entry_valid = r_valid;
    assign o_entry_count = OCNT_W'(r_out_count);
    assign o_last_of_run = r_last;

endmodule

@@ hdl/positional_list_engine_unit.sv @@
// Positional list engine: an ordered list held in a row of shifting cells.
// An operation is taken when i_start is high and o_busy is low. Inserts and
// deletes shift the whole row at once, so a new operation may be
// started every cycle and its single result shows o_strobe in the next cycle.
// A dump of n entries keeps o_busy high while the row rotates one entry to the
// head per cycle; its n results arrive after the start passes the state register
// and then the result registers (one result for an empty list, in the next
// cycle). Results last one cycle each and cannot be stalled by the receiver.
// Depends on ple_pkg, ple_ctrl and ple_cell.
module positional_list_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ple_pkg::MODE_W-1:0]    i_mode,
    input  logic [ple_pkg::POS_W-1:0]     i_position,
    input  logic signed [ple_pkg::VALUE_W-1:0] i_value,
    output logic                          o_busy,
    output logic                          o_strobe,
    output logic [ple_pkg::STATUS_W-1:0]  o_status,
    output logic signed [ple_pkg::VALUE_W-1:0] o_entry_value,
    output logic                          o_entry_valid,
    output logic [ple_pkg::OCNT_W-1:0]    o_entry_count,
    output logic                          o_last_of_run
);
    import ple_pkg::*;

    t_cell_cmd             w_cmd;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [VALUE_W-1:0]    w_entry_value;

    ple_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value       ($unsigned(i_value)),
        .i_head        (w_data[0]),
        .o_cmd         (w_cmd),
        .o_busy        (o_busy),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_entry_value (w_entry_value),
        .o_entry_valid (o_entry_valid),
        .o_entry_count (o_entry_count),
        .o_last_of_run (o_last_of_run)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        logic [DATA_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_data[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    assign o_entry_value = $signed(w_entry_value);

endmodule

@@ hdl/ple_checker.sv @@
// Port-level checks of the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_unit_defines.svh.
`include "positional_list_engine_unit_defines.svh"

module ple_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic [ple_pkg::MODE_W-1:0]    i_mode,
    input logic                          o_busy,
    input logic                          o_strobe,
    input logic [ple_pkg::STATUS_W-1:0]  o_status,
    input logic [ple_pkg::VALUE_W-1:0]   o_entry_value,
    input logic                          o_entry_valid,
    input logic [ple_pkg::OCNT_W-1:0]    o_entry_count,
    input logic                          o_last_of_run
);
    import ple_pkg::*;

    // every non-dump transfer answers with exactly one final result next cycle
    `PLE_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, i_start && !o_busy && i_mode != MODE_DUMP, o_strobe && o_last_of_run && !o_entry_valid)
    // each busy cycle delivers one dump entry in the following cycle
    `PLE_ASSERT_NEXT(a_dump_stream, i_clk, i_rst_n, o_busy, o_strobe && o_entry_valid && o_status == ST_OK)
    // results without an entry carry a zero value
    `PLE_ASSERT_NOW(a_empty_value, i_clk, i_rst_n, o_strobe && !o_entry_valid, o_entry_value == '0)
    // the count never passes the capacity
    `PLE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_strobe, o_entry_count <= OCNT_W'(DEPTH))

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .i_mode        (i_mode),
    .o_busy        (o_busy),
    .o_strobe      (o_strobe),
    .o_status      (o_status),
    .o_entry_value (o_entry_value),
    .o_entry_valid (o_entry_valid),
    .o_entry_count (o_entry_count),
    .o_last_of_run (o_last_of_run)
);

@@ test/tb_positional_list_engine_unit.sv @@
// Self-checking testbench for positional_list_engine_unit: directed list operations, then
// random sequences, mostly well-formed, that fill and drain the list, checked against a local model.
// Depends on ple_pkg and the positional_list_engine_unit RTL.
`timescale 1ns / 100ps

module tb_positional_list_engine_unit;

    import ple_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam logic [OCNT_W-1:0] FULL_COUNT  = OCNT_W'(DEPTH);
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_ITEMS  = 57;
    localparam int N_ROWS       = 20;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic                valid;
        logic [OCNT_W-1:0]   count;
        logic                last;
    } list_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  value;
        logic [4:0]          reps;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [OCNT_W-1:0]   count;
    } op_row_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic [MODE_W-1:0]         i_mode = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_busy;
    logic                      o_strobe;
    logic [STATUS_W-1:0]       o_status;
    logic signed [VALUE_W-1:0] o_entry_value;
    logic                      o_entry_valid;
    logic [OCNT_W-1:0]         o_entry_count;
    logic                      o_last_of_run;

    // local copy of the list contents
    logic [DATA_WIDTH-1:0] list_mirror [DEPTH];
    int                    list_len = 0;

    list_result_t fresh_results [$];
    list_result_t awaited_results [$];
    int           fault_count = 0;
    int           quiet_cycles = 0;

    // Typed expectations are single results; the others come from the model.
    op_row_t op_rows [N_ROWS] = '{
        '{MODE_DEL_FIRST, 5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,      5'd0},
        '{MODE_DEL_LAST,  5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,      5'd0},
        '{MODE_DEL_POS,   5'd1,  32'h0000_0000, 5'd1,  1'b1, ST_BAD_POS, 5'd0},
        '{MODE_INS_POS,   5'd0,  32'h1234_5678, 5'd1,  1'b1, ST_BAD_POS, 5'd0},
        '{MODE_DUMP,      5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,      5'd0},
        '{MODE_UNUSED,    5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,      5'd0},
        '{MODE_INS_FIRST, 5'd0,  32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,      5'd1},
        '{MODE_INS_LAST,  5'd0,  32'h8000_0000, 5'd1,  1'b1, ST_OK,      5'd2},
        '{MODE_INS_POS,   5'd2,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,      5'd3},
        '{MODE_INS_POS,   5'd31, 32'hAAAA_AAAA, 5'd1,  1'b1, ST_BAD_POS, 5'd3},
        '{MODE_DEL_POS,   5'd4,  32'h0000_0000, 5'd1,  1'b1, ST_BAD_POS, 5'd3},
        '{MODE_INS_POS,   5'd4,  32'h0000_0000, 5'd1,  1'b1, ST_OK,      5'd4},
        '{MODE_INS_LAST,  5'd0,  32'h5A5A_5A00, 5'd12, 1'b0, ST_OK,      5'd0},
        '{MODE_INS_FIRST, 5'd0,  32'h0F0F_0F0F, 5'd1,  1'b1, ST_FULL,    FULL_COUNT},
        '{MODE_INS_POS,   5'd17, 32'h0F0F_0F0F, 5'd1,  1'b1, ST_FULL,    FULL_COUNT},
        '{MODE_INS_POS,   5'd18, 32'h0F0F_0F0F, 5'd1,  1'b1, ST_BAD_POS, FULL_COUNT},
        '{MODE_DUMP,      5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,      5'd0},
        '{MODE_DEL_POS,   5'd16, 32'h0000_0000, 5'd1,  1'b1, ST_OK,      5'd15},
        '{MODE_DEL_POS,   5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_BAD_POS, 5'd15},
        '{MODE_DUMP,      5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,      5'd0}
    };

    positional_list_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_busy        (o_busy),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_entry_valid (o_entry_valid),
        .o_entry_count (o_entry_count),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void shift_in(input int idx, input logic [VALUE_W-1:0] v);
        for (int i = list_len; i > idx; i--) begin
            list_mirror[i] = list_mirror[i-1];
        end
        list_mirror[idx] = v[DATA_WIDTH-1:0];
        list_len++;
    endfunction

    function automatic void shift_out(input int idx);
        for (int i = idx; i + 1 < list_len; i++) begin
            list_mirror[i] = list_mirror[i+1];
        end
        list_len--;
    endfunction

    // Apply one operation to the mirror and collect the results it produces.
    function automatic void predict_list_op(input logic [MODE_W-1:0] m,
                                            input logic [POS_W-1:0] p,
                                            input logic [VALUE_W-1:0] v);
        logic [STATUS_W-1:0] st;
        int                  pos;
        st  = ST_OK;
        pos = int'(p);
        fresh_results.delete();
        case (m) inside
            MODE_INS_FIRST, MODE_INS_LAST: begin
                if (list_len >= DEPTH) st = ST_FULL;
                else shift_in((m == MODE_INS_FIRST) ? 0 : list_len, v);
            end
            MODE_INS_POS: begin
                if (pos < 1 || pos > list_len + 1) st = ST_BAD_POS;
                else if (list_len >= DEPTH) st = ST_FULL;
                else shift_in(pos - 1, v);
            end
            MODE_DEL_FIRST: begin
                if (list_len > 0) shift_out(0);
            end
            MODE_DEL_LAST: begin
                if (list_len > 0) shift_out(list_len - 1);
            end
            MODE_DEL_POS: begin
                if (pos < 1 || pos > list_len) st = ST_BAD_POS;
                else shift_out(pos - 1);
            end
            MODE_DUMP: begin
                if (list_len == 0) begin
                    fresh_results.push_back('{ST_OK, '0, 1'b0, '0, 1'b1});
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        fresh_results.push_back('{ST_OK, VALUE_W'(list_mirror[i]), 1'b1,
                                                  OCNT_W'(list_len), (i + 1 == list_len)});
                    end
                end
                return;
            end
            default: ;
        endcase
        fresh_results.push_back('{st, '0, 1'b0, OCNT_W'(list_len), 1'b1});
    endfunction

    // Hold start until the transfer, then queue what the operation should return.
    task automatic issue_op(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                            input logic [VALUE_W-1:0] v, input logic typed,
                            input list_result_t typed_result);
        i_start    <= 1'b1;
        i_mode     <= m;
        i_position <= p;
        i_value    <= v;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_list_op(m, p, v);
        if (typed) awaited_results.push_back(typed_result);
        else foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_check
        list_result_t want;
        logic         progress;
        progress = i_rst_n && i_start && !o_busy;
        if (i_rst_n && o_strobe) begin
            progress = 1'b1;
            if (awaited_results.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("unexpected result: status=%0d value=%h valid=%b count=%0d last=%b",
                             o_status, o_entry_value, o_entry_valid, o_entry_count,
                             o_last_of_run);
                fault_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status || o_entry_value !== want.value ||
                    o_entry_valid !== want.valid || o_entry_count !== want.count ||
                    o_last_of_run !== want.last) begin
                    if (fault_count < REPORT_LIMIT)
                        $display("mismatch: expected st=%0d val=%h vld=%b cnt=%0d last=%b, %s",
                                 want.status, want.value, want.valid, want.count, want.last,
                                 $sformatf("got st=%0d val=%h vld=%b cnt=%0d last=%b",
                                           o_status, o_entry_value, o_entry_valid,
                                           o_entry_count, o_last_of_run));
                    fault_count++;
                end
            end
        end
        quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end

    initial begin
        @(posedge i_clk);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("positional_list_engine_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        int                 gap_pct [4];
        logic [MODE_W-1:0]  m;
        logic [POS_W-1:0]   p;
        logic [VALUE_W-1:0] v;
        logic               growing;
        int                 roll;
        gap_pct = '{0, 64, 0, 12};
        growing = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (op_rows[r]) begin
            for (int k = 0; k < op_rows[r].reps; k++) begin
                issue_op(op_rows[r].mode, op_rows[r].pos, op_rows[r].value + VALUE_W'(k),
                         op_rows[r].typed, '{op_rows[r].status, '0, 1'b0,
                                             op_rows[r].count, 1'b1});
            end
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < gap_pct[ph]) begin
                    i_start <= 1'b0;
                    repeat ($urandom_range(6, 1)) @(posedge i_clk);
                end
                // swing between filling and draining so both ends get hit
                if (list_len == DEPTH) growing = 1'b0;
                else if (list_len == 0) growing = 1'b1;
                roll = $urandom_range(99);
                if (roll < 2) begin
                    m = MODE_UNUSED;
                end else if (roll < 12) begin
                    m = MODE_DUMP;
                end else if (roll < (growing ? 72 : 32)) begin
                    case ($urandom_range(2))
                        0:       m = MODE_INS_FIRST;
                        1:       m = MODE_INS_LAST;
                        default: m = MODE_INS_POS;
                    endcase
                end else begin
                    case ($urandom_range(2))
                        0:       m = MODE_DEL_FIRST;
                        1:       m = MODE_DEL_LAST;
                        default: m = MODE_DEL_POS;
                    endcase
                end
                p = POS_W'($urandom);
                if ($urandom_range(99) < 85) begin
                    if (m == MODE_INS_POS) p = POS_W'($urandom_range(list_len + 1, 1));
                    else if (m == MODE_DEL_POS && list_len > 0)
                        p = POS_W'($urandom_range(list_len, 1));
                end
                case ($urandom_range(19))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h0000_0000;
                    default: v = $urandom;
                endcase
                issue_op(m, p, v, 1'b0, '0);
            end
            drain_results();
        end

        repeat (24) @(posedge i_clk);
        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("positional_list_engine_unit verification clean");
        end else begin
            $display("positional_list_engine_unit verification failed");
        end
        $finish;
    end

endmodule
